FILE: rtl/fpte_pkg.sv
// Shared types and constants for the fern posterior classifier.
`timescale 1ns / 1ps
package fpte_pkg;
    localparam int NUM_TREES = 10;
    localparam int LEAF_BITS = 13;
    localparam int unsigned SCORE_W = 20;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned FRAC_W = 16;
    localparam logic [0:0] CFG_POS_THR = 1'b0;
    localparam logic [0:0] CFG_NEG_THR = 1'b1;
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_TRAIN = 1'b1;

    // Command from the sequencer to every tree lane.
    typedef struct packed {
        logic rd;
        logic upd;
        logic positive;
        logic clr;
    } t_lane_cmd;
endpackage

FILE: rtl/fpte_lane.sv
// One tree lane: count and weight memories, saturating update and weight divider.
`timescale 1ns / 1ps
module fpte_lane
    import fpte_pkg::*;
#(
    parameter int LEAF_BITS = 13,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_cmd             i_cmd,
    input  logic [LEAF_BITS-1:0]  i_addr,
    output logic [WEIGHT_W-1:0]   o_weight,
    output logic                  o_busy
);
    localparam int DEPTH = 1 << LEAF_BITS;
    localparam int NUM_W = COUNT_BITS + FRAC_W;
    localparam int DEN_W = COUNT_BITS + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [COUNT_BITS-1:0] r_pos_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_neg_mem [DEPTH];
    logic [WEIGHT_W-1:0]   r_w_mem   [DEPTH];

    logic [COUNT_BITS-1:0] r_pos;
    logic [COUNT_BITS-1:0] r_neg;
    logic [LEAF_BITS-1:0]  r_addr;
    logic                  r_pend;
    logic                  r_positive;
    logic                  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic [NUM_W-1:0]      r_quo;
    logic [DEN_W:0]        r_rem;
    logic [DEN_W-1:0]      r_den;
    logic [COUNT_BITS-1:0] n_pos;
    logic [COUNT_BITS-1:0] n_neg;
    logic [DEN_W:0]        n_rem;

    always_comb begin
        n_pos = r_pos;
        n_neg = r_neg;
        if (r_positive) begin
            if (r_pos != '1) n_pos = r_pos + 1'b1;
        end else begin
            if (r_neg != '1) n_neg = r_neg + 1'b1;
        end
        n_rem = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    end

    assign o_busy = r_pend || r_div;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_pos_mem[i_addr] <= '0;
            r_neg_mem[i_addr] <= '0;
            r_w_mem[i_addr] <= '0;
        end else if (i_cmd.rd) begin
            r_pos <= r_pos_mem[i_addr];
            r_neg <= r_neg_mem[i_addr];
            o_weight <= r_w_mem[i_addr];
            r_addr <= i_addr;
        end else if (r_pend) begin
            r_pos_mem[r_addr] <= n_pos;
            r_neg_mem[r_addr] <= n_neg;
            r_pos <= n_pos;
            r_quo <= {n_pos, {FRAC_W{1'b0}}};
            r_den <= DEN_W'(n_pos) + DEN_W'(n_neg);
            r_rem <= '0;
        end else if (r_div) begin
            if (n_rem >= {1'b0, r_den}) begin
                r_rem <= n_rem - {1'b0, r_den};
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
            if (r_cnt == CNT_W'(1)) begin
                r_w_mem[r_addr] <= (r_pos == '0) ? '0 :
                    WEIGHT_W'({r_quo[NUM_W-2:0], n_rem >= {1'b0, r_den}});
            end
        end
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_div <= 1'b0;
            r_cnt <= '0;
            r_positive <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                r_pend <= 1'b1;
                r_positive <= i_cmd.positive;
            end else if (r_pend) begin
                r_pend <= 1'b0;
                r_div <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_div) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) r_div <= 1'b0;
            end
        end
    end
endmodule

FILE: rtl/fpte_merge.sv
// Registered sum of the lane weights into the item score.
`timescale 1ns / 1ps
module fpte_merge
    import fpte_pkg::*;
#(
    parameter int NUM_TREES = 10
) (
    input  logic                 i_clk,
    input  logic [WEIGHT_W-1:0]  i_weight [NUM_TREES],
    output logic [SCORE_W-1:0]   o_score
);
    logic [SCORE_W-1:0] n_sum;

    always_comb begin
        n_sum = '0;
        for (int t = 0; t < NUM_TREES; t++) n_sum = n_sum + SCORE_W'(i_weight[t]);
    end

    always_ff @(posedge i_clk) begin
        o_score <= n_sum;
    end
endmodule

FILE: rtl/fern_posterior_train_eval_core.sv
// Top level of the fern posterior classifier with online training.
`timescale 1ns / 1ps
// One lane per tree holds that tree's counts and weights in local memories. After reset a
// clearing pass over all 2^LEAF_BITS leaves zeroes them; no item is taken meanwhile. An
// evaluate item steps through the read, sum and decide states; decide waits until the
// output register is free, loads the result and returns to idle. A training item that
// updates then also waits for the count write-back and a restoring divide of COUNT_BITS+16
// quotient bits, run in all lanes together, before the block returns to idle.
module fern_posterior_train_eval_core
    import fpte_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic                  i_label,
    input  logic [12:0]           i_leaf_0,
    input  logic [12:0]           i_leaf_1,
    input  logic [12:0]           i_leaf_2,
    input  logic [12:0]           i_leaf_3,
    input  logic [12:0]           i_leaf_4,
    input  logic [12:0]           i_leaf_5,
    input  logic [12:0]           i_leaf_6,
    input  logic [12:0]           i_leaf_7,
    input  logic [12:0]           i_leaf_8,
    input  logic [12:0]           i_leaf_9,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SCORE_W-1:0]    o_score,
    output logic                  o_trained,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [0:0]            i_cfg_index,
    input  logic [SCORE_W-1:0]    i_cfg_data
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_SUM, S_DECIDE, S_WAIT
    } t_state;

    t_state                r_state;
    logic [LEAF_BITS-1:0]  r_clr;
    logic [SCORE_W-1:0]    r_pos_thr;
    logic [SCORE_W-1:0]    r_neg_thr;
    logic                  r_op;
    logic                  r_label;
    logic [LEAF_BITS-1:0]  r_leaf [NUM_TREES];
    logic [12:0]           w_leaf [NUM_TREES];
    logic [WEIGHT_W-1:0]   w_weight [NUM_TREES];
    logic [NUM_TREES-1:0]  w_busy;
    logic [SCORE_W-1:0]    w_score;
    logic                  w_train;
    logic                  w_out_free;
    logic                  w_fire;
    t_lane_cmd             w_cmd;

    assign w_leaf = '{i_leaf_0, i_leaf_1, i_leaf_2, i_leaf_3, i_leaf_4,
                      i_leaf_5, i_leaf_6, i_leaf_7, i_leaf_8, i_leaf_9};
    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_train = (r_op == OP_TRAIN) &&
        (r_label ? (w_score <= r_pos_thr) : (w_score >= r_neg_thr));
    assign w_out_free = !o_valid || i_ready;
    assign w_fire = (r_state == S_DECIDE) && w_out_free;

    always_comb begin
        w_cmd.rd = (r_state == S_READ);
        w_cmd.upd = w_fire && w_train;
        w_cmd.positive = r_label;
        w_cmd.clr = (r_state == S_CLEAR);
    end

    for (genvar t = 0; t < NUM_TREES; t++) begin : g_lane
        fpte_lane #(.LEAF_BITS(LEAF_BITS), .COUNT_BITS(COUNT_BITS)) u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
            .i_addr((r_state == S_CLEAR) ? r_clr : r_leaf[t]),
            .o_weight(w_weight[t]), .o_busy(w_busy[t])
        );
    end

    fpte_merge #(.NUM_TREES(NUM_TREES)) u_merge (
        .i_clk(i_clk), .i_weight(w_weight), .o_score(w_score)
    );

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= i_opcode;
            r_label <= i_label;
            for (int t = 0; t < NUM_TREES; t++) r_leaf[t] <= w_leaf[t][LEAF_BITS-1:0];
        end
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_pos_thr <= SCORE_W'(327680);
            r_neg_thr <= SCORE_W'(327680);
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POS_THR: r_pos_thr <= i_cfg_data;
                    CFG_NEG_THR: r_neg_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_fire) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid && o_ready) r_state <= S_READ;
                S_READ: r_state <= S_SUM;
                S_SUM: r_state <= S_DECIDE;
                S_DECIDE: if (w_out_free) begin
                    o_score <= w_score;
                    o_trained <= w_train;
                    r_state <= w_train ? S_WAIT : S_IDLE;
                end
                S_WAIT: if (w_busy == '0) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready) else $error("Item taken during clearing pass.");
    a_eval_no_train: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_out_free && r_op == OP_EVAL) |=> !o_trained)
        else $error("Evaluate marked as trained.");
    a_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (w_busy == '0)) else $error("Lane busy at read.");
`endif
endmodule
